// ===== rtl/lrs_pkg.sv =====
// Shared types, widths and helpers for the line raster stepper.
`timescale 1ns / 1ps

package lrs_pkg;

  localparam int COORD_WIDTH = 11;
  localparam int ERR_WIDTH   = COORD_WIDTH + 2;
  localparam int COLOR_WIDTH = 32;

  localparam int IN_TDATA_BITS  = 4 * COORD_WIDTH + COLOR_WIDTH;
  localparam int IN_TDATA_W     = ((IN_TDATA_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = 2 * COORD_WIDTH + COLOR_WIDTH;
  localparam int OUT_TDATA_W    = ((OUT_TDATA_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Action codes carried in tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef logic [COORD_WIDTH-1:0]        coord_t;
  typedef logic signed [ERR_WIDTH-1:0]   err_t;
  typedef logic [COLOR_WIDTH-1:0]        color_t;

  // One classified command as it sits in the queue
  typedef struct packed {
    logic   is_start;
    coord_t cur_x;
    coord_t cur_y;
    coord_t end_x;
    coord_t end_y;
    coord_t span_x;
    coord_t span_y;
    logic   dir_x_neg;
    logic   dir_y_neg;
    logic   x_major;
    err_t   err;
    logic   active;
    color_t color;
  } cmd_t;

  function automatic coord_t step_coord(input coord_t v, input logic negative);
    step_coord = negative ? coord_t'(v - coord_t'(1)) : coord_t'(v + coord_t'(1));
  endfunction

endpackage

// ===== rtl/line_raster_stepper.sv =====
// Line raster stepper: one pixel per step word along a line between two endpoints.
//
// Input channel (s_axis_*): tuser selects the action, 0 loads a new line
// (endpoints and color from tdata), 1 advances one pixel. Output channel
// (m_axis_*): one word per emitted pixel, tlast marks the final pixel of
// the line. The end pixel itself is never sent; equal endpoints send nothing,
// and a step word with no line in progress is dropped silently.
// A step word is written into the command queue when it is accepted; once
// it reaches the head and the output register is free, its pixel is loaded
// into the stepper's output register, which drives m_axis_*.
// Throughput: one word per cycle on both sides, while the queue is not full
// and the receiver is ready; the stepper's one error term update per clock sets that rate.
// Input words pass through a four-entry command queue, so input is still
// taken while a pixel waits on a stalled receiver; the queue filling is what
// finally drops s_axis_tready_o.
// Reset clears the queue, the line-active flag and the output valid; the block
// accepts words once reset is released.
`timescale 1ns / 1ps

module line_raster_stepper import lrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: action
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: pixel_x, pixel_y, pixel_color, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tlast: last_pixel
  output logic                   m_axis_tlast_o
);

  logic push, fifo_full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  lrs_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  lrs_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_o       (head_cmd),
    .head_valid_o (head_valid)
  );

  lrs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== rtl/lrs_front.sv =====
// Input side: accepts words and turns start words into a ready-to-load line setup.
`timescale 1ns / 1ps

module lrs_front import lrs_pkg::*; (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  coord_t xs, ys, xe, ye;
  coord_t span_x, span_y, major;
  logic   x_lt, y_lt, x_major;

  assign xs = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign ys = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];
  assign xe = s_axis_tdata_i[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign ye = s_axis_tdata_i[4*COORD_WIDTH-1:3*COORD_WIDTH];

  assign x_lt    = xs < xe;
  assign y_lt    = ys < ye;
  assign span_x  = x_lt ? coord_t'(xe - xs) : coord_t'(xs - xe);
  assign span_y  = y_lt ? coord_t'(ye - ys) : coord_t'(ys - ye);
  assign x_major = span_x >= span_y;
  assign major   = x_major ? span_x : span_y;

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.is_start  = (s_axis_tuser_i == ACT_START);
    cmd_o.cur_x     = xs;
    cmd_o.cur_y     = ys;
    cmd_o.end_x     = xe;
    cmd_o.end_y     = ye;
    cmd_o.span_x    = span_x;
    cmd_o.span_y    = span_y;
    cmd_o.dir_x_neg = !x_lt;
    cmd_o.dir_y_neg = !y_lt;
    cmd_o.x_major   = x_major;
    cmd_o.err       = err_t'({2'b00, 1'b0, major[COORD_WIDTH-1:1]});
    cmd_o.active    = (major != '0);
    cmd_o.color     = s_axis_tdata_i[IN_TDATA_BITS-1:4*COORD_WIDTH];
  end

endmodule

// ===== rtl/lrs_cmd_fifo.sv =====
// Short command queue between the input side and the stepper.
`timescale 1ns / 1ps

module lrs_cmd_fifo import lrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic head_valid_o
);

  cmd_t                  entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? FIFO_PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? FIFO_PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = FIFO_CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = FIFO_CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/lrs_back.sv =====
// Stepper: loads line setups, walks the line and holds the pixel output register.
`timescale 1ns / 1ps

module lrs_back import lrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  cmd_t                   head_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d, end_x_q, end_x_d, end_y_q, end_y_d;
  coord_t span_x_q, span_x_d, span_y_q, span_y_d;
  logic   dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d, x_major_q, x_major_d;
  err_t   err_q, err_d;
  color_t color_q, color_d;
  logic   active_q, active_d;

  logic   out_valid_q, out_valid_d, out_last_q, out_last_d;
  coord_t out_x_q, out_x_d, out_y_q, out_y_d;
  color_t out_color_q, out_color_d;

  logic   out_ready, emit;
  err_t   minor_ext, major_ext, err_sub, err_new;
  logic   borrow;
  coord_t nx, ny;
  logic   still_active;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign pop_o     = head_valid_i && (head_i.is_start || !active_q || out_ready);
  assign emit      = pop_o && !head_i.is_start && active_q;

  // Error-term update for one step along the major axis
  assign minor_ext = x_major_q ? err_t'({2'b00, span_y_q}) : err_t'({2'b00, span_x_q});
  assign major_ext = x_major_q ? err_t'({2'b00, span_x_q}) : err_t'({2'b00, span_y_q});
  assign err_sub   = err_t'(err_q - minor_ext);
  assign borrow    = err_sub[ERR_WIDTH-1];
  assign err_new   = borrow ? err_t'(err_sub + major_ext) : err_sub;

  always_comb begin
    if (x_major_q) begin
      nx           = step_coord(cur_x_q, dir_x_neg_q);
      ny           = borrow ? step_coord(cur_y_q, dir_y_neg_q) : cur_y_q;
      still_active = (nx != end_x_q);
    end else begin
      ny           = step_coord(cur_y_q, dir_y_neg_q);
      nx           = borrow ? step_coord(cur_x_q, dir_x_neg_q) : cur_x_q;
      still_active = (ny != end_y_q);
    end
  end

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    end_x_d     = end_x_q;
    end_y_d     = end_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    x_major_d   = x_major_q;
    err_d       = err_q;
    color_d     = color_q;
    active_d    = active_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (pop_o && head_i.is_start) begin
      cur_x_d     = head_i.cur_x;
      cur_y_d     = head_i.cur_y;
      end_x_d     = head_i.end_x;
      end_y_d     = head_i.end_y;
      span_x_d    = head_i.span_x;
      span_y_d    = head_i.span_y;
      dir_x_neg_d = head_i.dir_x_neg;
      dir_y_neg_d = head_i.dir_y_neg;
      x_major_d   = head_i.x_major;
      err_d       = head_i.err;
      color_d     = head_i.color;
      active_d    = head_i.active;
    end else if (emit) begin
      out_valid_d = 1'b1;
      out_x_d     = cur_x_q;
      out_y_d     = cur_y_q;
      out_color_d = color_q;
      out_last_d  = !still_active;
      cur_x_d     = nx;
      cur_y_d     = ny;
      err_d       = err_new;
      active_d    = still_active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    end_x_q     <= end_x_d;
    end_y_q     <= end_y_d;
    span_x_q    <= span_x_d;
    span_y_q    <= span_y_d;
    dir_x_neg_q <= dir_x_neg_d;
    dir_y_neg_q <= dir_y_neg_d;
    x_major_q   <= x_major_d;
    err_q       <= err_d;
    color_q     <= color_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_color_q, out_y_q, out_x_q});

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("step on active line produced no word");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !err_q[ERR_WIDTH-1])
    else $error("error term negative on an active line");

  a_not_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (x_major_q ? (cur_x_q != end_x_q) : (cur_y_q != end_y_q)))
    else $error("active line already at its end pixel");

endmodule
